[rtl/core/indexed_min_heap_engine_core_assert.svh]
// Assertion macros used by the checker file.
`ifndef INDEXED_MIN_HEAP_ENGINE_CORE_ASSERT_SVH
`define INDEXED_MIN_HEAP_ENGINE_CORE_ASSERT_SVH

// Implication checked at every edge outside reset.
`define IMH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define IMH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/imh_pkg.sv]
package imh_pkg;
    localparam int CAPACITY     = 1024;
    localparam int HANDLE_COUNT = 1024;
    localparam int AW = $clog2(CAPACITY);
    localparam int HW = 11;
    localparam int CW = 11;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELMIN = 3'd2;
    localparam logic [2:0] OP_DELH   = 3'd3;
    localparam logic [2:0] OP_CHG    = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_BADH  = 2'd3;

    // memory write request
    typedef struct packed {
        logic          we;
        logic [AW-1:0] addr;
        logic [31:0]   val;
        logic [HW-1:0] hdl;
    } t_slot_wr;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] addr;
        logic [CW-1:0] pos;
    } t_pos_wr;
endpackage

[rtl/core/imh_slot_mem.sv]
module imh_slot_mem import imh_pkg::*; (
    input  logic          i_clk,
    input  t_slot_wr      i_wr,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_val,
    output logic [HW-1:0] o_hdl
);
    logic [31:0]   r_val [CAPACITY];
    logic [HW-1:0] r_hdl [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_val[i_wr.addr] <= i_wr.val;
            r_hdl[i_wr.addr] <= i_wr.hdl;
        end
        o_val <= r_val[i_raddr];
        o_hdl <= r_hdl[i_raddr];
    end
endmodule

[rtl/core/imh_pos_mem.sv]
module imh_pos_mem import imh_pkg::*; (
    input  logic          i_clk,
    input  t_pos_wr       i_wr,
    input  logic [AW-1:0] i_raddr,
    output logic [CW-1:0] o_pos
);
    logic [CW-1:0] r_pos [HANDLE_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) r_pos[i_wr.addr] <= i_wr.pos;
        o_pos <= r_pos[i_raddr];
    end
endmodule

[rtl/core/indexed_min_heap_engine_core.sv]
// Indexed binary min-heap engine.
// Input channel: i_valid / o_stall with i_opcode, i_handle_in, i_value_in.
// Output channel: o_valid / i_stall with o_status, o_min_value,
// o_handle_out, o_entry_count; one result item per input item.
// One item is processed at a time: o_stall stays high from acceptance until
// the result item leaves, so a new item gets in only after the last result.
// Memories have registered reads. Peek and items rejected on entry skip the
// heap work and go on to read the root for the result; a handle is checked
// by a position lookup and a slot read first. Insert writes the new entry,
// then sifts up level by level (read parent, compare, write both slots).
// Delete min first moves the last entry into the root, then sifts down level
// by level (read both children, compare, write both slots); delete and change
// by handle add the lookup, and a stale handle that it finds is rejected.
// Slot memory holds value and handle per slot; a second memory maps each
// handle to its slot. The root value is kept in a register for the result.
// Synchronous active-low reset empties the heap and restarts handles at 1;
// memories need no clearing. While the output item is stalled the result
// register holds and the block accepts no new item.
module indexed_min_heap_engine_core import imh_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [2:0]    i_opcode,
    input  logic [HW-1:0] i_handle_in,
    input  logic signed [31:0] i_value_in,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [1:0]    o_status,
    output logic signed [31:0] o_min_value,
    output logic [HW-1:0] o_handle_out,
    output logic [CW-1:0] o_entry_count
);
    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_HREAD = 12'b000000000010,
        S_HCHK  = 12'b000000000100,
        S_PREP  = 12'b000000001000,
        S_DREAD = 12'b000000010000,
        S_DL    = 12'b000000100000,
        S_DR    = 12'b000001000000,
        S_DCMP  = 12'b000010000000,
        S_UREAD = 12'b000100000000,
        S_UPAR  = 12'b001000000000,
        S_SWAP  = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } t_state;

    t_state r_state;
    logic [2:0]    r_op;
    logic [HW-1:0] r_hid;
    logic [31:0]   r_val;
    logic [CW-1:0] r_size, r_next;
    logic [31:0]   r_root;
    logic [1:0]    r_status;
    logic [HW-1:0] r_hout;
    // current entry (pos, value, handle) and the other slot being compared
    logic [CW-1:0] r_p;
    logic [31:0]   r_pv;
    logic [HW-1:0] r_ph;
    logic [CW-1:0] r_t;
    logic [31:0]   r_tv;
    logic [HW-1:0] r_th;
    logic          r_up;      // after swap, continue sifting up
    logic [1:0]    r_sw;      // swap phase
    logic [2:0]    r_pre;     // prepare phase

    t_slot_wr      w_sw;
    t_pos_wr       w_pw;
    logic [AW-1:0] w_sra;
    logic [31:0]   m_val;
    logic [HW-1:0] m_hdl;
    logic [AW-1:0] w_pra;
    logic [CW-1:0] m_pos;

    imh_slot_mem u_slot (
        .i_clk(i_clk), .i_wr(w_sw), .i_raddr(w_sra), .o_val(m_val), .o_hdl(m_hdl)
    );
    imh_pos_mem u_pos (
        .i_clk(i_clk), .i_wr(w_pw), .i_raddr(w_pra), .o_pos(m_pos)
    );

    function automatic logic slt(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic logic [AW-1:0] sa(logic [CW-1:0] s);
        logic [CW-1:0] d;
        d = s - CW'(1);
        return d[AW-1:0];
    endfunction

    logic w_acc;
    assign o_stall = (r_state != S_IDLE);
    assign w_acc   = i_valid && (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT) && (r_pre == 3'd2);
    assign o_status = r_status;
    assign o_min_value = (r_size != '0) ? r_root : 32'd0;
    assign o_handle_out = r_hout;
    assign o_entry_count = r_size;

    logic [CW-1:0] w_l, w_r, w_par;
    assign w_l   = {r_p[CW-2:0], 1'b0};
    assign w_r   = {r_p[CW-2:0], 1'b1};
    assign w_par = r_p >> 1;

    always_comb begin
        w_sw = '0;
        w_pw = '0;
        w_sra = sa(r_p);
        w_pra = r_hid[AW-1:0] - AW'(1);
        case (r_state)
            // issue the position read with the incoming handle
            S_IDLE:  w_pra = i_handle_in[AW-1:0] - AW'(1);
            S_DREAD: w_sra = sa(w_l);
            S_DL:    w_sra = sa(w_r);
            S_UREAD: w_sra = sa(w_par);
            S_PREP: begin
                if (r_op == OP_INSERT) begin
                    w_sw = '{we: 1'b1, addr: sa(r_p), val: r_pv, hdl: r_ph};
                    w_pw = '{we: 1'b1, addr: sa(r_ph), pos: r_p};
                end else if (r_op == OP_CHG) begin
                    w_sw = '{we: 1'b1, addr: sa(r_p), val: r_pv, hdl: r_ph};
                end else if (r_pre == 3'd0) begin
                    w_sra = sa(r_size);
                end else if (r_pre == 3'd2) begin
                    // move last entry into the vacated slot
                    w_sw = '{we: 1'b1, addr: sa(r_p), val: r_tv, hdl: r_th};
                    w_pw = '{we: 1'b1, addr: sa(r_th), pos: r_p};
                end
            end
            S_SWAP: begin
                if (r_sw == 2'd0) begin
                    w_sw = '{we: 1'b1, addr: sa(r_p), val: r_tv, hdl: r_th};
                    w_pw = '{we: 1'b1, addr: sa(r_th), pos: r_p};
                end else begin
                    w_sw = '{we: 1'b1, addr: sa(r_t), val: r_pv, hdl: r_ph};
                    w_pw = '{we: 1'b1, addr: sa(r_ph), pos: r_t};
                end
            end
            S_OUT: begin
                w_sra = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_size  <= '0;
            r_next  <= CW'(1);
        end else begin
            case (r_state)
                S_IDLE: if (w_acc) begin
                    r_op <= i_opcode; r_hid <= i_handle_in; r_val <= i_value_in;
                    r_status <= ST_OK; r_hout <= '0; r_pre <= '0; r_sw <= '0;
                    case (i_opcode)
                        OP_INSERT: begin
                            if (r_size >= CW'(CAPACITY) || r_next > CW'(HANDLE_COUNT)) begin
                                r_status <= ST_FULL; r_state <= S_UREAD;
                            end else begin
                                r_p <= r_size + CW'(1); r_pv <= i_value_in;
                                r_ph <= r_next; r_hout <= r_next;
                                r_size <= r_size + CW'(1); r_next <= r_next + CW'(1);
                                r_state <= S_PREP;
                            end
                        end
                        OP_DELMIN: begin
                            if (r_size == '0) begin
                                r_status <= ST_EMPTY; r_state <= S_UREAD;
                            end else begin
                                r_p <= CW'(1); r_state <= S_PREP;
                            end
                        end
                        OP_DELH, OP_CHG: begin
                            if (i_handle_in == '0 || i_handle_in >= r_next
                                || i_handle_in > HW'(HANDLE_COUNT)) begin
                                r_status <= ST_BADH; r_state <= S_UREAD;
                            end else begin
                                r_state <= S_HREAD;
                            end
                        end
                        default: begin
                            if (r_size == '0) r_status <= ST_EMPTY;
                            r_state <= S_UREAD;
                        end
                    endcase
                    if (i_opcode != OP_INSERT && i_opcode != OP_DELMIN
                        && i_opcode != OP_DELH && i_opcode != OP_CHG) r_p <= CW'(1);
                    r_up <= 1'b0;
                end
                S_HREAD: begin
                    // position read result available; fetch its slot next
                    r_p <= m_pos; r_state <= S_HCHK; r_pre <= 3'd0;
                end
                S_HCHK: begin
                    if (r_pre == 3'd0) begin
                        r_pre <= 3'd1;   // slot read issued this cycle
                    end else if (r_p == '0 || r_p > r_size || m_hdl != r_hid) begin
                        r_status <= ST_BADH; r_p <= CW'(1); r_state <= S_UREAD;
                    end else begin
                        r_pre <= 3'd0;
                        if (r_op == OP_CHG) begin
                            r_pv <= r_val; r_ph <= r_hid;
                        end
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (r_op == OP_INSERT) begin
                        r_up <= 1'b1; r_state <= S_UREAD;
                    end else if (r_op == OP_CHG) begin
                        r_up <= 1'b0; r_state <= S_DREAD;
                    end else begin
                        case (r_pre)
                            3'd0: r_pre <= 3'd1;
                            3'd1: begin
                                r_tv <= m_val; r_th <= m_hdl; r_pre <= 3'd2;
                            end
                            default: begin
                                r_size <= r_size - CW'(1);
                                if (r_p == r_size) begin
                                    r_p <= CW'(1); r_state <= S_UREAD; r_up <= 1'b0;
                                end else begin
                                    r_pv <= r_tv; r_ph <= r_th;
                                    r_up <= 1'b0; r_state <= S_DREAD;
                                end
                            end
                        endcase
                    end
                end
                S_DREAD: begin
                    if (w_l > r_size || r_p[CW-1]) begin
                        // no children: start sifting up
                        r_up <= 1'b1; r_state <= S_UREAD;
                    end else begin
                        r_state <= S_DL;
                    end
                end
                S_DL: begin
                    r_t <= r_p; r_tv <= r_pv; r_th <= r_ph;
                    if (slt(m_val, r_pv)) begin
                        r_t <= w_l; r_tv <= m_val; r_th <= m_hdl;
                    end
                    r_state <= (w_r <= r_size) ? S_DR : S_DCMP;
                end
                S_DR: begin
                    if (slt(m_val, r_tv)) begin
                        r_t <= w_r; r_tv <= m_val; r_th <= m_hdl;
                    end
                    r_state <= S_DCMP;
                end
                S_DCMP: begin
                    if (r_t == r_p) begin
                        r_up <= 1'b1; r_state <= S_UREAD;
                    end else begin
                        r_sw <= 2'd0; r_state <= S_SWAP;
                    end
                end
                S_UREAD: begin
                    if (!r_up || r_p <= CW'(1)) begin
                        r_p <= CW'(1); r_state <= S_OUT; r_up <= 1'b0;
                        r_pre <= 3'd0;
                    end else begin
                        r_state <= S_UPAR;
                    end
                end
                S_UPAR: begin
                    if (slt(r_pv, m_val)) begin
                        r_t <= w_par; r_tv <= m_val; r_th <= m_hdl;
                        r_sw <= 2'd0; r_state <= S_SWAP;
                    end else begin
                        r_p <= CW'(1); r_up <= 1'b0; r_state <= S_OUT;
                        r_pre <= 3'd0;
                    end
                end
                S_SWAP: begin
                    if (r_sw == 2'd0) begin
                        r_sw <= 2'd1;
                    end else begin
                        r_p <= r_t;
                        r_state <= r_up ? S_UREAD : S_DREAD;
                    end
                end
                S_OUT: begin
                    // root read issued on entry; capture once, then hold
                    if (r_pre == 3'd0) r_pre <= 3'd1;
                    else if (r_pre == 3'd1) begin
                        r_root <= m_val; r_pre <= 3'd2;
                    end else if (!i_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/core/imh_checker.sv]
`include "indexed_min_heap_engine_core_assert.svh"
module imh_checker import imh_pkg::*; (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input logic          o_valid,
    input logic          i_stall,
    input logic [1:0]    o_status,
    input logic [HW-1:0] o_handle_out,
    input logic [CW-1:0] o_entry_count
);
    `IMH_ASSERT_IMP(a_busy, i_clk, i_rst_n, o_valid, o_stall, "result shown while accepting")
    `IMH_ASSERT_IMP(a_hout, i_clk, i_rst_n, o_valid && o_status != ST_OK, o_handle_out == '0, "handle on failure")
    `IMH_ASSERT_IMP(a_cap, i_clk, i_rst_n, o_valid, o_entry_count <= CW'(CAPACITY), "count above capacity")
    `IMH_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status), "stalled result dropped")
endmodule

bind indexed_min_heap_engine_core imh_checker u_imh_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
    .o_handle_out(o_handle_out), .o_entry_count(o_entry_count)
);

[tb/sv/indexed_min_heap_engine_core_tb.sv]
`timescale 1ns / 1ps

module indexed_min_heap_engine_core_tb;
    import imh_pkg::*;

    localparam logic [2:0] OP_PEEK = 3'd1;

    class heap_scoreboard;
        typedef struct {
            logic [1:0]         st;
            logic signed [31:0] mn;
            logic [HW-1:0]      hdl;
            logic [CW-1:0]      cnt;
        } t_heap_result;

        t_heap_result       expected_q[$];
        int                 errors;
        logic signed [31:0] slot_val[1:CAPACITY];
        int                 slot_hdl[1:CAPACITY];
        int                 hdl_slot[1:HANDLE_COUNT];
        int                 size;
        int                 next_hdl;

        function new();
            errors = 0;
            size = 0;
            next_hdl = 1;
            foreach (hdl_slot[i]) hdl_slot[i] = 0;
            foreach (slot_hdl[i]) slot_hdl[i] = 0;
        endfunction

        function bit less(int a, int b);
            return slot_val[a] < slot_val[b];
        endfunction

        function void swap_slots(int a, int b);
            int ha;
            int hb;
            logic signed [31:0] v;
            ha = slot_hdl[a];
            hb = slot_hdl[b];
            v = slot_val[a];
            hdl_slot[ha] = b;
            hdl_slot[hb] = a;
            slot_hdl[a] = hb;
            slot_hdl[b] = ha;
            slot_val[a] = slot_val[b];
            slot_val[b] = v;
        endfunction

        function void sift_down(int p);
            int t;
            forever begin
                t = p;
                if (2 * p <= size && less(2 * p, t)) t = 2 * p;
                if (2 * p + 1 <= size && less(2 * p + 1, t)) t = 2 * p + 1;
                if (t == p) break;
                swap_slots(t, p);
                p = t;
            end
        endfunction

        function void sift_up(int p);
            while (p > 1 && less(p, p / 2)) begin
                swap_slots(p / 2, p);
                p = p / 2;
            end
        endfunction

        // slot of a live handle, 0 when the handle is stale or unknown
        function int live_slot(int h);
            int p;
            if (h == 0 || h >= next_hdl || h > HANDLE_COUNT) return 0;
            p = hdl_slot[h];
            if (p == 0 || p > size) return 0;
            if (slot_hdl[p] != h) return 0;
            return p;
        endfunction

        function void note_input(logic [2:0] op, logic [HW-1:0] h, logic signed [31:0] v);
            t_heap_result r;
            int p;
            r.st = ST_OK;
            r.hdl = '0;
            case (op)
                OP_INSERT: begin
                    if (size >= CAPACITY || next_hdl > HANDLE_COUNT) begin
                        r.st = ST_FULL;
                    end else begin
                        size++;
                        slot_val[size] = v;
                        slot_hdl[size] = next_hdl;
                        hdl_slot[next_hdl] = size;
                        r.hdl = HW'(next_hdl);
                        next_hdl++;
                        sift_up(size);
                    end
                end
                OP_DELMIN: begin
                    if (size == 0) begin
                        r.st = ST_EMPTY;
                    end else begin
                        swap_slots(1, size);
                        size--;
                        sift_down(1);
                    end
                end
                OP_DELH: begin
                    p = live_slot(h);
                    if (p == 0) begin
                        r.st = ST_BADH;
                    end else begin
                        swap_slots(p, size);
                        size--;
                        if (p <= size) begin
                            sift_down(p);
                            sift_up(p);
                        end
                    end
                end
                OP_CHG: begin
                    p = live_slot(h);
                    if (p == 0) begin
                        r.st = ST_BADH;
                    end else begin
                        slot_val[p] = v;
                        sift_down(p);
                        sift_up(p);
                    end
                end
                default: begin
                    if (size == 0) r.st = ST_EMPTY;
                end
            endcase
            r.mn = (size > 0) ? slot_val[1] : '0;
            r.cnt = CW'(size);
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [1:0] st, logic signed [31:0] mn, logic [HW-1:0] h,
                          logic [CW-1:0] cnt);
            t_heap_result e;
            if (expected_q.size() == 0) begin
                report("result item with nothing expected");
            end else begin
                e = expected_q.pop_front();
                if (st !== e.st) report($sformatf("status %0d, expected %0d", st, e.st));
                if (mn !== e.mn) report($sformatf("min %0d, expected %0d", mn, e.mn));
                if (h !== e.hdl) report($sformatf("handle %0d, expected %0d", h, e.hdl));
                if (cnt !== e.cnt) report($sformatf("count %0d, expected %0d", cnt, e.cnt));
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [2:0]         i_opcode;
    logic [HW-1:0]      i_handle_in;
    logic signed [31:0] i_value_in;
    logic               o_valid;
    logic               i_stall;
    logic [1:0]         o_status;
    logic signed [31:0] o_min_value;
    logic [HW-1:0]      o_handle_out;
    logic [CW-1:0]      o_entry_count;

    heap_scoreboard heap_sb;
    bit             hold_off_req;
    bit             no_idle;

    indexed_min_heap_engine_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_handle_in  (i_handle_in),
        .i_value_in   (i_value_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_min_value  (o_min_value),
        .o_handle_out (o_handle_out),
        .o_entry_count(o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3, 4: return $signed($urandom_range(0, 16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    function logic [HW-1:0] pick_handle();
        if ($urandom_range(0, 99) < 85 && heap_sb.next_hdl > 1)
            return HW'($urandom_range(1, heap_sb.next_hdl - 1));
        return HW'($urandom_range(0, 2047));
    endfunction

    task send_item(logic [2:0] op, logic [HW-1:0] h, logic signed [31:0] v);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_opcode = op;
        i_handle_in = h;
        i_value_in = v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        heap_sb.note_input(op, h, v);
    endtask

    task wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (heap_sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    // receiver: random stalls, and one long hold-off on request
    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_stall = 1'b1;
                repeat (300) @(negedge i_clk);
                i_stall = 1'b0;
            end else begin
                n = idle_len();
                i_stall = (n > 0);
                repeat (n > 0 ? n - 1 : 0) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            heap_sb.check_result(o_status, o_min_value, o_handle_out, o_entry_count);
    end

    initial begin
        logic [2:0] op;
        heap_sb = new();
        hold_off_req = 1'b0;
        no_idle = 1'b0;
        i_valid = 1'b0;
        i_opcode = OP_PEEK;
        i_handle_in = '0;
        i_value_in = '0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty heap: peek, delete min, stale handles, unused opcodes; then inserts, changes and deletes
        send_item(OP_PEEK, 0, 0);
        send_item(OP_DELMIN, 0, 0);
        send_item(OP_DELH, 0, 0);
        send_item(OP_CHG, 5, 7);
        send_item(3'd5, 11'h7ff, -1);
        send_item(3'd6, 0, 0);
        send_item(3'd7, 0, 0);
        send_item(OP_INSERT, 0, 32'sh7fff_ffff);
        send_item(OP_INSERT, 11'h7ff, 32'sh8000_0000);
        send_item(OP_INSERT, 0, 0);
        send_item(OP_INSERT, 0, -1);
        send_item(OP_INSERT, 0, 5);
        send_item(OP_PEEK, 0, 0);
        send_item(OP_CHG, 2, 100);
        send_item(OP_CHG, 1, 32'sh8000_0000);
        send_item(OP_DELH, 3, 0);
        send_item(OP_DELH, 3, 0);
        send_item(OP_DELH, 2047, 0);
        send_item(OP_CHG, 1024, 1);
        // largest value lands in the last slot, so its delete does no sift
        send_item(OP_INSERT, 0, 32'sh7fff_ffff);
        send_item(OP_DELH, 6, 0);
        send_item(OP_DELMIN, 0, 0);
        send_item(OP_DELMIN, 0, 0);
        send_item(3'd7, 0, 0);

        for (int i = 0; i < 1350; i++) begin
            if (i == 300) hold_off_req = 1'b1;
            if (i == 600) wait_drained();
            no_idle = (i >= 800 && i < 900);
            if (heap_sb.next_hdl <= HANDLE_COUNT)
                op = ($urandom_range(0, 99) < 80) ? OP_INSERT : 3'($urandom_range(1, 7));
            else
                op = ($urandom_range(0, 99) < 10) ? OP_INSERT : 3'($urandom_range(1, 7));
            send_item(op, pick_handle(), pick_value());
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (heap_sb.errors == 0 && heap_sb.expected_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
